[src/mlpd_pkg.sv]
// ----------------------------------------------------------------------------
// mlpd_pkg
// Shared constants and types for the multichannel length-prefix deframer.
// ----------------------------------------------------------------------------
package mlpd_pkg;

  localparam int CHAN_W   = 6;
  localparam int CHANNELS = 1 << CHAN_W;
  localparam int LEN_W    = 32;
  localparam int ADDR_W   = 3;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_ERROR   = 2'd2;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_EMPTY     = 2'd1;
  localparam logic [1:0] KIND_TOO_LARGE = 2'd2;

  localparam logic [ADDR_W-1:0] REG_MAX_FRAME_LENGTH = 3'd0;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET        = 32'd65536;

  // Per-channel deframing state as kept in the state memory.
  typedef struct packed {
    logic [1:0]       phase;
    logic [1:0]       hdr_count;
    logic [LEN_W-1:0] length;
  } chan_state_t;

endpackage

[src/multichannel_length_prefix_deframer_top.sv]
// ----------------------------------------------------------------------------
// multichannel_length_prefix_deframer_top
// Per-channel 32-bit big-endian length-prefix deframer with state in memory.
// ----------------------------------------------------------------------------
// A result is loaded into the output register when the update stage advances
// after its input transaction is accepted (memory read at accept, then update).
// Throughput: one byte per cycle on any mix of channels unless out_stall holds
// a result; same-channel back-to-back bytes forward the state being written back.
// Reset: rst clears every channel's state at once through per-entry valid
// bits and sets max_frame_length to 65536; no clearing pass is needed.
module multichannel_length_prefix_deframer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlpd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [mlpd_pkg::CHAN_W-1:0]   channel,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mlpd_pkg::CHAN_W-1:0]   out_channel,
  output logic [1:0]                    kind,
  output logic [7:0]                    payload_byte,
  output logic                          last_of_frame
);
  import mlpd_pkg::*;

  logic [LEN_W-1:0] max_frame_length;

  chan_state_t      state_mem [CHANNELS];
  logic [CHANNELS-1:0] entry_valid;
  chan_state_t      mem_rd;

  logic              s1_valid;
  logic              s1_opcode;
  logic [CHAN_W-1:0] s1_channel;
  logic [7:0]        s1_byte;
  logic              s1_fwd;
  chan_state_t       s1_fwd_state;
  logic              s1_entry_valid;

  chan_state_t       cur;
  chan_state_t       state_next;
  logic              has_result;
  logic [1:0]        res_kind;
  logic [7:0]        res_byte;
  logic              res_last;
  logic              s1_adv;
  logic              in_accept;
  logic [LEN_W-1:0]  hdr_len;
  logic [2:0]        hdr_cnt;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_FRAME_LENGTH) ? max_frame_length : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_MAX_FRAME_LENGTH[ADDR_W-1:2]) begin
      max_frame_length <= pwdata;
    end
  end

  // Handshake of the update stage.
  assign s1_adv    = s1_valid && (!has_result || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // State memory: synchronous read at accept, write-back from the update stage.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rd <= state_mem[channel];
    end
    if (s1_adv) begin
      state_mem[s1_channel] <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (s1_adv) begin
      entry_valid[s1_channel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // The memory read misses a write-back to the same channel in the same
  // cycle, so that value is captured and used in place of the read data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode      <= opcode;
      s1_channel     <= channel;
      s1_byte        <= data_byte;
      s1_fwd         <= s1_adv && (s1_channel == channel);
      s1_fwd_state   <= state_next;
      s1_entry_valid <= entry_valid[channel];
    end
  end

  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_state;
    end else if (s1_entry_valid) begin
      cur = mem_rd;
    end else begin
      cur = '0;
    end
  end

  assign hdr_len = {cur.length[LEN_W-9:0], s1_byte};
  assign hdr_cnt = {1'b0, cur.hdr_count} + 3'd1;

  always_comb begin
    state_next = cur;
    has_result = 1'b0;
    res_kind   = KIND_BYTE;
    res_byte   = 8'd0;
    res_last   = 1'b0;
    if (s1_opcode == OP_CLEAR) begin
      state_next = '0;
    end else begin
      case (cur.phase)
        PH_HEADER: begin
          if (hdr_cnt < 3'd4) begin
            state_next.length    = hdr_len;
            state_next.hdr_count = hdr_cnt[1:0];
          end else begin
            state_next.hdr_count = 2'd0;
            if (hdr_len == '0) begin
              state_next.length = '0;
              has_result        = 1'b1;
              res_kind          = KIND_EMPTY;
            end else if (hdr_len > max_frame_length) begin
              state_next.length = '0;
              state_next.phase  = PH_ERROR;
              has_result        = 1'b1;
              res_kind          = KIND_TOO_LARGE;
            end else begin
              state_next.length = hdr_len;
              state_next.phase  = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          has_result = 1'b1;
          res_kind   = KIND_BYTE;
          res_byte   = s1_byte;
          if (cur.length <= 32'd1) begin
            state_next = '0;
            res_last   = 1'b1;
          end else begin
            state_next.length = cur.length - 32'd1;
          end
        end
        default: begin
          // Error phase and the unused code drop bytes silently.
          state_next = cur;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_channel   <= s1_channel;
      kind          <= res_kind;
      payload_byte  <= res_byte;
      last_of_frame <= res_last;
    end
  end

endmodule

[src/mlpd_checker.sv]
// ----------------------------------------------------------------------------
// mlpd_checker
// Port-level checks for the multichannel length-prefix deframer.
// ----------------------------------------------------------------------------
module mlpd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pready,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mlpd_pkg::CHAN_W-1:0] out_channel,
  input logic [1:0]                  kind,
  input logic [7:0]                  payload_byte,
  input logic                        last_of_frame
);
  import mlpd_pkg::*;

  // Only the three defined result kinds are ever shown.
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_BYTE || kind == KIND_EMPTY || kind == KIND_TOO_LARGE))
    else $error("illegal result kind");

  // Header results carry no byte and no frame end mark.
  a_header_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_BYTE) |-> (payload_byte == 8'd0 && !last_of_frame))
    else $error("header result carries payload data");

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_channel) && $stable(kind)
                                  && $stable(payload_byte) && $stable(last_of_frame)))
    else $error("stalled result changed");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready deasserted");

endmodule

bind multichannel_length_prefix_deframer_top mlpd_checker u_mlpd_checker (
  .clk           (clk),
  .rst           (rst),
  .pready        (pready),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_channel   (out_channel),
  .kind          (kind),
  .payload_byte  (payload_byte),
  .last_of_frame (last_of_frame)
);
